// File: rtl/ppm_pkg.sv
// ppm_pkg: shared types and constants for the pixel priority mux.
// Request/result payload structs, sprite lane record, merge result.
// No dependencies.
package ppm_pkg;

    localparam int SPRITE_LANES    = 8;   // 1..8
    localparam int PALETTE_ENTRIES = 32;
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);

    localparam logic REQ_RENDER = 1'b0;
    localparam logic REQ_WRITE  = 1'b1;

    localparam int EN_BG = 0;   // render_enables bit: show background
    localparam int EN_SP = 1;   // render_enables bit: show sprites

    localparam logic [5:0] PALETTE_PAGE = 6'h3F;   // address bits 13..8 of 3F00-3FFF
    localparam int         ATTR_BEHIND  = 5;       // attribute bit: behind background

    typedef struct packed {
        logic        req_type;
        logic [31:0] bg_pattern_bits;
        logic [31:0] bg_attribute_bits;
        logic [2:0]  fine_x;
        logic [1:0]  render_enables;
        logic [13:0] vaddr;
        logic        sprite_zero_in_line;
        logic [7:0]  sprite_active;
        logic [15:0] sprite_pattern_bits;
        logic [63:0] sprite_attributes;
        logic [7:0]  palette_data;
    } req_t;

    typedef struct packed {
        logic [7:0] pix_color;
        logic       sprite_zero_hit;
    } res_t;

    // what one sprite lane reports for the current dot
    typedef struct packed {
        logic       opaque;   // active and pixel nonzero
        logic [1:0] pix;
        logic [2:0] pal;      // sprite palettes live at 4..7
        logic       front;
    } lane_t;

    typedef struct packed {
        logic [PAL_AW-1:0] index;
        logic              hit;
    } merge_t;

endpackage

// File: rtl/ppm_sprite_lane.sv
// ppm_sprite_lane: one sprite lane, decodes its pixel, palette and priority.
// Depends on ppm_pkg.
module ppm_sprite_lane
(
    input  logic               active,
    input  logic               plane_lo,
    input  logic               plane_hi,
    input  logic [7:0]         attr,
    output ppm_pkg::lane_t     lane
);

    always_comb
    begin
        lane.pix    = {plane_hi, plane_lo};
        lane.opaque = active && (plane_hi || plane_lo);
        lane.pal    = {1'b1, attr[1:0]};
        lane.front  = !attr[ppm_pkg::ATTR_BEHIND];
    end

endmodule

// File: rtl/ppm_merge.sv
// ppm_merge: picks the first opaque sprite lane, the background pixel,
// applies layer priority and forms the palette index and sprite-zero hit.
// Depends on ppm_pkg.
module ppm_merge
(
    input  ppm_pkg::lane_t  lanes [ppm_pkg::SPRITE_LANES],
    input  logic [31:0]     bg_pattern_bits,
    input  logic [31:0]     bg_attribute_bits,
    input  logic [2:0]      fine_x,
    input  logic [1:0]      render_enables,
    input  logic [13:0]     vaddr,
    input  logic            sprite_zero_in_line,
    output ppm_pkg::merge_t merged
);

    logic           bg_on;
    logic           sp_on;
    logic [3:0]     bg_pos;
    logic [1:0]     bg_pix;
    logic [1:0]     bg_pal;
    ppm_pkg::lane_t fg;
    logic           fg_is_lane0;

    assign bg_on  = render_enables[ppm_pkg::EN_BG];
    assign sp_on  = render_enables[ppm_pkg::EN_SP];
    assign bg_pos = {1'b1, ~fine_x};   // 15 - fine_x

    always_comb
    begin
        if (bg_on)
        begin
            bg_pix = {bg_pattern_bits[16 + int'(bg_pos)], bg_pattern_bits[bg_pos]};
            bg_pal = {bg_attribute_bits[16 + int'(bg_pos)], bg_attribute_bits[bg_pos]};
        end
        else
        begin
            bg_pix = 2'b00;
            bg_pal = 2'b00;
        end
    end

    // lowest-numbered opaque lane wins; scan from the top so it lands last
    always_comb
    begin
        fg          = '0;
        fg_is_lane0 = 1'b0;
        for (int i = ppm_pkg::SPRITE_LANES - 1; i >= 0; i--)
        begin
            if (lanes[i].opaque)
            begin
                fg          = lanes[i];
                fg_is_lane0 = (i == 0);
            end
        end
        if (!sp_on)
        begin
            fg          = '0;
            fg_is_lane0 = 1'b0;
        end
    end

    always_comb
    begin
        merged.hit = fg.opaque && fg_is_lane0 && sprite_zero_in_line && (bg_pix != 2'b00);
        if (!bg_on && !sp_on)
        begin
            // forced-blank: video address points straight into palette space
            if (vaddr[13:8] == ppm_pkg::PALETTE_PAGE)
                merged.index = vaddr[ppm_pkg::PAL_AW-1:0];
            else
                merged.index = '0;
        end
        else if (fg.opaque && ((bg_pix == 2'b00) || fg.front))
            merged.index = {fg.pal, fg.pix};
        else if (bg_pix != 2'b00)
            merged.index = {1'b0, bg_pal, bg_pix};
        else
            merged.index = '0;
    end

endmodule

// File: rtl/ppu_pixel_priority_mux.sv
// ppu_pixel_priority_mux: top level, sprite lanes, merge, palette registers
// and result register. Depends on ppm_pkg, ppm_sprite_lane, ppm_merge.
//
//   channel | signals                       | direction | payload
//   request | req_valid req_ready req_data  | in        | ppm_pkg::req_t
//   result  | res_valid res_ready res_data  | out       | ppm_pkg::res_t
//
// One request per cycle. A render request gives its result in the cycle
// after acceptance (one result register); a palette write gives none and
// updates the entry at the accepting edge, so a following render sees it.
// Reset clears the 32 palette entries at once; no clearing pass.
// A stalled result holds req_ready low until it is taken.
module ppu_pixel_priority_mux
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  ppm_pkg::req_t  req_data,
    output logic           res_valid,
    input  logic           res_ready,
    output ppm_pkg::res_t  res_data
);

    ppm_pkg::lane_t  lanes [ppm_pkg::SPRITE_LANES];
    ppm_pkg::merge_t merged;

    logic [7:0]    pal_reg [ppm_pkg::PALETTE_ENTRIES];
    logic          res_valid_reg;
    logic          res_valid_next;
    ppm_pkg::res_t res_reg;
    ppm_pkg::res_t res_next;
    logic          req_fire;
    logic          render_fire;
    logic          write_fire;

    for (genvar g = 0; g < ppm_pkg::SPRITE_LANES; g++)
    begin : g_lane
        ppm_sprite_lane u_lane
        (
            .active   (req_data.sprite_active[g]),
            .plane_lo (req_data.sprite_pattern_bits[g]),
            .plane_hi (req_data.sprite_pattern_bits[8 + g]),
            .attr     (req_data.sprite_attributes[8*g +: 8]),
            .lane     (lanes[g])
        );
    end

    ppm_merge u_merge
    (
        .lanes               (lanes),
        .bg_pattern_bits     (req_data.bg_pattern_bits),
        .bg_attribute_bits   (req_data.bg_attribute_bits),
        .fine_x              (req_data.fine_x),
        .render_enables      (req_data.render_enables),
        .vaddr               (req_data.vaddr),
        .sprite_zero_in_line (req_data.sprite_zero_in_line),
        .merged              (merged)
    );

    assign req_ready   = !res_valid_reg || res_ready;
    assign req_fire    = req_valid && req_ready;
    assign render_fire = req_fire && (req_data.req_type == ppm_pkg::REQ_RENDER);
    assign write_fire  = req_fire && (req_data.req_type == ppm_pkg::REQ_WRITE);

    always_comb
    begin
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        if (render_fire)
        begin
            res_valid_next           = 1'b1;
            res_next.pix_color       = pal_reg[merged.index];
            res_next.sprite_zero_hit = merged.hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            for (int i = 0; i < ppm_pkg::PALETTE_ENTRIES; i++)
                pal_reg[i] <= '0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (write_fire)
                pal_reg[req_data.vaddr[ppm_pkg::PAL_AW-1:0]] <= req_data.palette_data;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    a_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
        write_fire |=> pal_reg[$past(req_data.vaddr[ppm_pkg::PAL_AW-1:0])]
                       == $past(req_data.palette_data))
        else $error("palette write not stored");

    a_render_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        render_fire |=> res_valid)
        else $error("render request produced no result");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (write_fire && !res_valid_reg) |=> !res_valid)
        else $error("write request produced a result");

    a_hit_needs_sprites: assert property (@(posedge clk) disable iff (!rst_n)
        (render_fire && !req_data.render_enables[ppm_pkg::EN_SP]) |=> !res_data.sprite_zero_hit)
        else $error("sprite-zero hit with sprites off");

    a_blank_entry0: assert property (@(posedge clk) disable iff (!rst_n)
        (render_fire && (req_data.render_enables == 2'b00)
         && (req_data.vaddr[13:8] != ppm_pkg::PALETTE_PAGE))
        |=> (res_data.pix_color == pal_reg[0]))
        else $error("blanked pixel outside palette space not entry 0");

endmodule

// File: tb/ppu_pixel_priority_mux_test.sv
// Testbench for ppu_pixel_priority_mux: directed and random pixel/palette requests,
// checked against an in-bench priority predictor with random gaps and a long output stall.
// Depends on ppm_pkg and the ppu_pixel_priority_mux RTL.
module ppu_pixel_priority_mux_test;

    import ppm_pkg::*;

    localparam int CYCLE_LIMIT   = 100000;
    localparam int REPORT_LIMIT  = 10;
    localparam int IDLE_PERCENT  = 16;
    localparam int STALL_CYCLES  = 48;
    localparam int RANDOM_ITEMS  = 420;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req_data;
    logic res_valid;
    logic res_ready;
    res_t res_data;

    logic [7:0] palette_shadow [PALETTE_ENTRIES];
    res_t       expected_pixels[$];

    int  cycle_count;
    int  mismatches;
    int  pixels_checked;
    int  hits_checked;
    int  renders_sent;
    int  writes_sent;
    int  hold_cycles;
    bit  no_gaps;

    ppu_pixel_priority_mux u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // background pick, first opaque sprite lane, priority, palette lookup
    function automatic res_t predict_pixel(input req_t r);
        logic [4:0] bg_pix;
        logic [1:0] bg_pal;
        logic [1:0] fg_pix;
        logic [2:0] fg_pal;
        logic       fg_front;
        logic       hit;
        logic [4:0] pix;
        logic [2:0] pal;
        logic [7:0] attr;
        logic [1:0] lane_pix;
        logic [4:0] entry;
        int         pos;
        res_t       res;
        bg_pix   = '0;
        bg_pal   = '0;
        fg_pix   = '0;
        fg_pal   = '0;
        fg_front = 1'b0;
        hit      = 1'b0;
        pix      = '0;
        pal      = '0;
        if (r.render_enables[EN_BG])
        begin
            pos    = 15 - int'(r.fine_x);
            bg_pix = {3'b000, r.bg_pattern_bits[pos + 16], r.bg_pattern_bits[pos]};
            bg_pal = {r.bg_attribute_bits[pos + 16], r.bg_attribute_bits[pos]};
        end
        // rendering off: the address itself points into the palette
        if (!r.render_enables[EN_BG] && !r.render_enables[EN_SP]
            && r.vaddr[13:8] == PALETTE_PAGE)
        begin
            bg_pix = r.vaddr[4:0];
        end
        if (r.render_enables[EN_SP])
        begin
            for (int lane = 0; lane < SPRITE_LANES; lane++)
            begin
                lane_pix = {r.sprite_pattern_bits[lane + 8], r.sprite_pattern_bits[lane]};
                if (fg_pix == 2'b00 && r.sprite_active[lane] && lane_pix != 2'b00)
                begin
                    attr     = r.sprite_attributes[lane*8 +: 8];
                    fg_pix   = lane_pix;
                    fg_pal   = {1'b1, attr[1:0]};
                    fg_front = !attr[ATTR_BEHIND];
                    hit      = r.sprite_zero_in_line && lane == 0 && bg_pix != 5'd0;
                end
            end
        end
        if (fg_pix != 2'b00 && (bg_pix == 5'd0 || fg_front))
        begin
            pal = fg_pal;
            pix = {3'b000, fg_pix};
        end
        else if (bg_pix != 5'd0)
        begin
            pal = {1'b0, bg_pal};
            pix = bg_pix;
        end
        entry               = {pal, 2'b00} | pix;
        res.pix_color       = palette_shadow[entry];
        res.sprite_zero_hit = hit;
        return res;
    endfunction

    function automatic req_t blank_render();
        req_t r;
        r          = '0;
        r.req_type = REQ_RENDER;
        return r;
    endfunction

    function automatic req_t random_render();
        req_t r;
        r.req_type            = REQ_RENDER;
        r.bg_pattern_bits     = 32'($urandom);
        r.bg_attribute_bits   = 32'($urandom);
        r.fine_x              = 3'($urandom_range(7));
        r.render_enables      = 2'($urandom_range(3));
        r.vaddr               = 14'($urandom_range(16383));
        r.sprite_zero_in_line = 1'($urandom_range(1));
        r.sprite_active       = 8'($urandom_range(255));
        r.sprite_pattern_bits = 16'($urandom_range(65535));
        r.sprite_attributes   = {32'($urandom), 32'($urandom)};
        r.palette_data        = 8'($urandom_range(255));
        if (r.render_enables == 2'b00 && $urandom_range(1) == 1)
            r.vaddr[13:8] = PALETTE_PAGE;
        // thin out the active lanes so the later lanes win now and then
        if ($urandom_range(1) == 1)
            r.sprite_active = r.sprite_active & 8'($urandom) & 8'($urandom);
        return r;
    endfunction

    function automatic req_t random_write();
        req_t r;
        r          = random_render();
        r.req_type = REQ_WRITE;
        return r;
    endfunction

    function automatic req_t random_request();
        if ($urandom_range(4) == 0)
            return random_write();
        return random_render();
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input req_t r);
        while (!no_gaps && $urandom_range(99) < IDLE_PERCENT)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        if (r.req_type == REQ_WRITE)
        begin
            palette_shadow[r.vaddr[4:0]] = r.palette_data;
            writes_sent++;
        end
        else
        begin
            expected_pixels.push_back(predict_pixel(r));
            renders_sent++;
        end
        @(negedge clk);
    endtask

    task automatic test_reset_palette();
        req_t r;
        r       = blank_render();
        r.vaddr = 14'h3F00;
        send_request(r);
        r.vaddr = 14'h3F1F;
        send_request(r);
    endtask

    task automatic test_palette_writes();
        req_t w;
        req_t r;
        w              = blank_render();
        w.req_type     = REQ_WRITE;
        w.vaddr        = 14'h3F00;
        w.palette_data = 8'hFF;
        send_request(w);
        w.vaddr        = 14'h3FFF;
        w.palette_data = 8'hA5;
        send_request(w);
        // outside the palette page the low bits still select the entry
        w.vaddr        = 14'h0005;
        w.palette_data = 8'h5A;
        send_request(w);
        w.vaddr        = 14'h3F10;
        w.palette_data = 8'h01;
        send_request(w);
        r              = blank_render();
        r.vaddr        = 14'h3F00;
        send_request(r);
        r.vaddr        = 14'h3F1F;
        send_request(r);
        r.vaddr        = 14'h3F05;
        send_request(r);
        r.vaddr        = 14'h1234;
        send_request(r);
    endtask

    task automatic test_background();
        req_t r;
        r                   = blank_render();
        r.render_enables    = 2'b01;
        r.bg_pattern_bits   = 32'hFFFF_FFFF;
        r.fine_x            = 3'd0;
        send_request(r);
        r.bg_pattern_bits   = 32'h0000_0100;
        r.bg_attribute_bits = 32'hFFFF_FFFF;
        r.fine_x            = 3'd7;
        send_request(r);
        r.bg_pattern_bits   = 32'h7FFF_7FFF;
        r.fine_x            = 3'd0;
        send_request(r);
    endtask

    task automatic test_sprites();
        req_t r;
        r                     = blank_render();
        r.render_enables      = 2'b11;
        r.bg_pattern_bits     = 32'hFFFF_FFFF;
        r.sprite_active       = 8'h01;
        r.sprite_pattern_bits = 16'h0001;
        r.sprite_attributes   = 64'h03;
        send_request(r);                          // sprite in front
        r.sprite_attributes   = 64'h23;
        send_request(r);                          // sprite behind opaque background
        r.bg_pattern_bits     = 32'h0;
        send_request(r);                          // behind, but background clear
        r.bg_pattern_bits     = 32'hFFFF_FFFF;
        r.sprite_active       = 8'h81;
        r.sprite_pattern_bits = 16'h8000;         // lane 0 clear, lane 7 opaque
        r.sprite_attributes   = 64'h0200_0000_0000_00FF;
        send_request(r);
        r.sprite_zero_in_line = 1'b1;
        r.sprite_active       = 8'hFF;
        r.sprite_pattern_bits = 16'hFFFF;
        r.sprite_attributes   = 64'h21;
        send_request(r);                          // sprite zero hit, behind background
        r.bg_pattern_bits     = 32'h0;
        send_request(r);                          // no hit on clear background
        r.bg_pattern_bits     = 32'hFFFF_FFFF;
        r.sprite_zero_in_line = 1'b0;
        send_request(r);
        r.sprite_zero_in_line = 1'b1;
        r.render_enables      = 2'b01;
        send_request(r);                          // sprites off
        r.render_enables      = 2'b10;
        r.vaddr               = 14'h3F05;
        send_request(r);                          // no direct address with sprites on
    endtask

    task automatic test_random_mix();
        req_t r;
        for (int i = 0; i < PALETTE_ENTRIES; i++)
        begin
            r            = random_write();
            r.vaddr[4:0] = 5'(i);
            send_request(r);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_request(random_request());
    endtask

    task automatic test_full_rate();
        no_gaps = 1'b1;
        for (int i = 0; i < 60; i++)
            send_request(random_request());
        no_gaps = 1'b0;
    endtask

    task automatic test_output_stall();
        no_gaps     = 1'b1;
        hold_cycles = STALL_CYCLES;
        for (int i = 0; i < 20; i++)
            send_request(random_render());
        no_gaps = 1'b0;
    endtask

    // result side readiness; a pending hold-off wins over everything
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            res_ready   <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end
        else if (no_gaps)
            res_ready <= 1'b1;
        else
            res_ready <= ($urandom_range(99) >= IDLE_PERCENT);
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: color %h hit %b",
                             res_data.pix_color, res_data.sprite_zero_hit);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (res_data.pix_color !== want.pix_color
                    || res_data.sprite_zero_hit !== want.sprite_zero_hit)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("pixel %0d: color exp %h got %h, hit exp %b got %b",
                                 pixels_checked, want.pix_color, res_data.pix_color,
                                 want.sprite_zero_hit, res_data.sprite_zero_hit);
                end
                pixels_checked++;
                if (want.sprite_zero_hit)
                    hits_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_pixels.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req_data       = '0;
        res_ready      = 1'b0;
        hold_cycles    = 0;
        no_gaps        = 1'b0;
        cycle_count    = 0;
        mismatches     = 0;
        pixels_checked = 0;
        hits_checked   = 0;
        renders_sent   = 0;
        writes_sent    = 0;
        for (int i = 0; i < PALETTE_ENTRIES; i++)
            palette_shadow[i] = 8'h00;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_palette();
        test_palette_writes();
        test_background();
        test_sprites();
        test_random_mix();
        test_full_rate();
        test_output_stall();

        req_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("%0d render requests checked (%0d with sprite-zero hit), %0d palette writes,",
                 pixels_checked, hits_checked, writes_sent);
        $display("with random gaps, a full-rate stretch and a %0d-cycle output stall",
                 STALL_CYCLES);
        if (mismatches == 0 && pixels_checked == renders_sent)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
